// ----- src/sphash_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sphash_pkg: shared types and constants for the synonym string hash
// Code points, register indexes, reset values and the status bundle of the
// modular multiply unit.
// ----------------------------------------------------------------------------
package sphash_pkg;

  localparam int CHAR_WIDTH      = 21;
  localparam int CFG_WIDTH       = 32;
  localparam int CFG_INDEX_WIDTH = 1;

  // synonym separator, '|'
  localparam logic [CHAR_WIDTH-1:0] SEP_CODE = 21'd124;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BASE    = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS = 1'b1;

  localparam logic [CFG_WIDTH-1:0] BASE_RESET    = 32'd131;
  localparam logic [CFG_WIDTH-1:0] MODULUS_RESET = 32'd1000000007;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_status_t;

endpackage
`default_nettype wire

// ----- src/sphash_mulmod.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sphash_mulmod: bit-serial modular multiplier
// Computes (mplier * addend) mod modulus, one multiplier bit per cycle,
// MSB first, with doubling, add and a single correction per step.
// addend must be below modulus.
// ----------------------------------------------------------------------------
module sphash_mulmod import sphash_pkg::*; #(
  parameter int MOD_WIDTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  input  wire logic [((MOD_WIDTH + 1 > CHAR_WIDTH) ?
                      MOD_WIDTH + 1 : CHAR_WIDTH)-1:0] mplier,
  input  wire logic [$clog2(((MOD_WIDTH + 1 > CHAR_WIDTH) ?
                      MOD_WIDTH + 1 : CHAR_WIDTH) + 1)-1:0] nbits,
  input  wire logic [MOD_WIDTH-1:0]                   addend,
  input  wire logic [MOD_WIDTH:0]                     modulus,
  output logic      [MOD_WIDTH-1:0]                   result,
  output mm_status_t                                  stat
);

  localparam int MW = (MOD_WIDTH + 1 > CHAR_WIDTH) ? MOD_WIDTH + 1 : CHAR_WIDTH;
  localparam int CW = $clog2(MW + 1);

  logic [MW-1:0]        mreg;
  logic [MOD_WIDTH-1:0] acc;
  logic [CW-1:0]        cnt;
  logic                 done;

  logic [MOD_WIDTH+1:0] t;
  logic [MOD_WIDTH+1:0] m1;
  logic [MOD_WIDTH+1:0] m2;
  logic [MOD_WIDTH+1:0] t_sub1;
  logic [MOD_WIDTH+1:0] t_sub2;
  logic [MOD_WIDTH-1:0] acc_next;

  // 2*acc + bit*addend stays below 3*modulus
  assign t      = {1'b0, acc, 1'b0} + (mreg[MW-1] ? {2'b00, addend} : '0);
  assign m1     = {1'b0, modulus};
  assign m2     = {modulus, 1'b0};
  assign t_sub1 = t - m1;
  assign t_sub2 = t - m2;

  always_comb begin
    priority if (t >= m2) begin
      acc_next = t_sub2[MOD_WIDTH-1:0];
    end else if (t >= m1) begin
      acc_next = t_sub1[MOD_WIDTH-1:0];
    end else begin
      acc_next = t[MOD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mreg <= mplier;
        acc  <= '0;
        cnt  <= nbits;
      end else if (cnt != '0) begin
        mreg <= {mreg[MW-2:0], 1'b0};
        acc  <= acc_next;
        cnt  <= cnt - CW'(1);
        done <= (cnt == CW'(1));
      end
    end
  end

  assign result    = acc;
  assign stat.busy = (cnt != '0);
  assign stat.done = done;

  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    stat.done |-> !stat.busy)
    else $error("mulmod: done raised while still stepping");

  a_start_busy : assert property (@(posedge clk) disable iff (rst)
    start && nbits != '0 |=> stat.busy)
    else $error("mulmod: start did not begin stepping");

  a_done_after_step : assert property (@(posedge clk) disable iff (rst)
    stat.done |-> $past(stat.busy))
    else $error("mulmod: done raised without a final step");

endmodule
`default_nettype wire

// ----- src/synonym_polynomial_string_hash_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// synonym_polynomial_string_hash_top: synonym-aware polynomial word hash
// Characters of a word come in one per transfer; '|' splits the word into
// segments, each hashed as sum c_i * base^(i+1) mod modulus, and the segment
// hashes are summed with plain wrap-around and emitted on the last character.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+-----------------------------------
//  char     | char_valid/char_stall  | char_code[20:0], last_char
//  hash     | hash_valid/hash_stall  | word_hash[HASH_WIDTH-1:0]
//  config   | cfg_write              | cfg_index[0:0], cfg_data[31:0]
//
//  Sequence: a separator goes straight to the close state. Any other
//  character runs the one bit-serial modular multiplier twice, for
//  c*power, then power*base. A power reload (base mod modulus) comes
//  first after reset, a config write or a segment restart, and a full
//  reduction of the running sum comes between the two when the running
//  sum is not already below the modulus (only after a mid-word write).
//  Reset: synchronous; registers go to base 131 and modulus 1000000007.
//  Stalls: a finished word total sits in the output register; the next
//  character is taken meanwhile, and only a following last character waits
//  for the slot to drain.
// ----------------------------------------------------------------------------
module synonym_polynomial_string_hash_top import sphash_pkg::*; #(
  parameter int MOD_WIDTH  = 32,
  parameter int HASH_WIDTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // character channel
  input  wire logic                       char_valid,
  output logic                            char_stall,
  input  wire logic [CHAR_WIDTH-1:0]      char_code,
  input  wire logic                       last_char,
  // hash channel
  output logic                            hash_valid,
  input  wire logic                       hash_stall,
  output logic [HASH_WIDTH-1:0]           word_hash,
  // configuration
  input  wire logic                       cfg_write,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_WIDTH-1:0]       cfg_data
);

  localparam int W  = MOD_WIDTH;
  localparam int MW = (W + 1 > CHAR_WIDTH) ? W + 1 : CHAR_WIDTH;
  localparam int CW = $clog2(MW + 1);

  localparam int SH_CHAR = MW - CHAR_WIDTH;
  localparam int SH_BASE = MW - W;
  localparam int SH_SUM  = MW - W - 1;

  localparam logic [CW-1:0] NB_CHAR = CW'(CHAR_WIDTH);
  localparam logic [CW-1:0] NB_BASE = CW'(W);
  localparam logic [CW-1:0] NB_SUM  = CW'(W + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;  // power reload: base mod modulus
  localparam logic [2:0] S_TERM = 3'd2;  // c * power mod modulus
  localparam logic [2:0] S_SRED = 3'd3;  // full reduction of the running sum
  localparam logic [2:0] S_POW  = 3'd4;  // power * base mod modulus
  localparam logic [2:0] S_DONE = 3'd5;  // segment close and output

  logic [2:0]            state;

  // configuration, only the low MOD_WIDTH bits ever matter
  logic [W-1:0]          base_reg;
  logic [W-1:0]          mod_reg;

  // hash state
  logic [W-1:0]          seg_sum;
  logic [W-1:0]          pos_power;
  logic                  pp_stale;   // pos_power must be reloaded first
  logic [HASH_WIDTH-1:0] word_total;

  // current character
  logic [CHAR_WIDTH-1:0] cur_char;
  logic                  cur_last;
  logic                  cur_sep;

  // multiply unit command
  logic                  mm_start;
  logic [MW-1:0]         mm_mplier;
  logic [CW-1:0]         mm_nbits;
  logic [W-1:0]          mm_addend;
  logic [W-1:0]          mm_result;
  mm_status_t            mm_stat;

  logic [W:0]            m_eff;
  logic [W-1:0]          one_addend;
  logic                  in_sep;
  logic [MW-1:0]         mp_in_char;
  logic [MW-1:0]         mp_cur_char;
  logic [MW-1:0]         mp_base;
  logic [MW-1:0]         mp_sum;
  logic [W:0]            seg_plus;
  logic [W:0]            seg_plus_sub;
  logic [W-1:0]          seg_quick;
  logic                  seg_lt;
  logic [HASH_WIDTH-1:0] total_close;

  // modulus zero means plain wrap at 2^MOD_WIDTH
  assign m_eff      = (mod_reg == '0) ? {1'b1, {W{1'b0}}} : {1'b0, mod_reg};
  // "1 mod modulus" as multiplicand, so a pass just reduces the multiplier
  assign one_addend = {{(W-1){1'b0}}, (m_eff != (W+1)'(1))};

  assign in_sep      = (char_code == SEP_CODE);
  assign mp_in_char  = MW'(char_code) << SH_CHAR;
  assign mp_cur_char = MW'(cur_char) << SH_CHAR;
  assign mp_base     = MW'(base_reg) << SH_BASE;
  assign mp_sum      = MW'(seg_plus) << SH_SUM;

  // running sum plus fresh term; one subtract is enough while seg_sum < m
  assign seg_plus     = {1'b0, seg_sum} + {1'b0, mm_result};
  assign seg_plus_sub = seg_plus - m_eff;
  assign seg_lt       = ({1'b0, seg_sum} < m_eff);
  assign seg_quick    = (seg_plus >= m_eff) ? seg_plus_sub[W-1:0] : seg_plus[W-1:0];

  assign total_close = word_total + HASH_WIDTH'(seg_sum);

  assign char_stall = (state != S_IDLE);

  sphash_mulmod #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .start   (mm_start),
    .mplier  (mm_mplier),
    .nbits   (mm_nbits),
    .addend  (mm_addend),
    .modulus (m_eff),
    .result  (mm_result),
    .stat    (mm_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      hash_valid <= 1'b0;
      base_reg   <= BASE_RESET[W-1:0];
      mod_reg    <= MODULUS_RESET[W-1:0];
      seg_sum    <= '0;
      word_total <= '0;
      pp_stale   <= 1'b1;
      mm_start   <= 1'b0;
    end else begin
      mm_start <= 1'b0;
      if (hash_valid && !hash_stall) begin
        hash_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (char_valid) begin
            cur_char <= char_code;
            cur_last <= last_char;
            cur_sep  <= in_sep;
            if (in_sep) begin
              state <= S_DONE;
            end else if (pp_stale) begin
              mm_start  <= 1'b1;
              mm_mplier <= mp_base;
              mm_nbits  <= NB_BASE;
              mm_addend <= one_addend;
              state     <= S_PREP;
            end else begin
              mm_start  <= 1'b1;
              mm_mplier <= mp_in_char;
              mm_nbits  <= NB_CHAR;
              mm_addend <= pos_power;
              state     <= S_TERM;
            end
          end
        end

        S_PREP: begin
          if (mm_stat.done) begin
            pos_power <= mm_result;
            pp_stale  <= 1'b0;
            mm_start  <= 1'b1;
            mm_mplier <= mp_cur_char;
            mm_nbits  <= NB_CHAR;
            mm_addend <= mm_result;
            state     <= S_TERM;
          end
        end

        S_TERM: begin
          if (mm_stat.done) begin
            mm_start <= 1'b1;
            if (seg_lt) begin
              seg_sum   <= seg_quick;
              mm_mplier <= mp_base;
              mm_nbits  <= NB_BASE;
              mm_addend <= pos_power;
              state     <= S_POW;
            end else begin
              mm_mplier <= mp_sum;
              mm_nbits  <= NB_SUM;
              mm_addend <= one_addend;
              state     <= S_SRED;
            end
          end
        end

        S_SRED: begin
          if (mm_stat.done) begin
            seg_sum   <= mm_result;
            mm_start  <= 1'b1;
            mm_mplier <= mp_base;
            mm_nbits  <= NB_BASE;
            mm_addend <= pos_power;
            state     <= S_POW;
          end
        end

        S_POW: begin
          if (mm_stat.done) begin
            pos_power <= mm_result;
            state     <= S_DONE;
          end
        end

        S_DONE: begin
          if (cur_last) begin
            // separator or not, the close adds the open segment once
            if (!hash_valid || !hash_stall) begin
              word_hash  <= total_close;
              hash_valid <= 1'b1;
              word_total <= '0;
              seg_sum    <= '0;
              pp_stale   <= 1'b1;
              state      <= S_IDLE;
            end
          end else begin
            if (cur_sep) begin
              word_total <= total_close;
              seg_sum    <= '0;
              pp_stale   <= 1'b1;
            end
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase

      // the user must only write while idle (the block does not enforce it); the power reloads on the next character
      if (cfg_write) begin
        unique case (cfg_index)
          REG_BASE:    base_reg <= cfg_data[W-1:0];
          REG_MODULUS: mod_reg  <= cfg_data[W-1:0];
        endcase
        pp_stale <= 1'b1;
      end
    end
  end

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_stall |=> char_stall)
    else $error("hash: character transfer did not start the sequencer");

  a_idle_unit : assert property (@(posedge clk) disable iff (rst)
    !char_stall |-> !mm_stat.busy)
    else $error("hash: multiplier still stepping while ready for input");

  a_load_done : assert property (@(posedge clk) disable iff (rst)
    $rose(hash_valid) |-> $past(state == S_DONE))
    else $error("hash: result loaded outside the close state");

endmodule
`default_nettype wire
